/* src/quaternion_to_yaw_degrees_core_assert.svh */
// assertion macros used by the checker file
`ifndef QUATERNION_TO_YAW_DEGREES_CORE_ASSERT_SVH
`define QUATERNION_TO_YAW_DEGREES_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define QTYD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define QTYD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/qtyd_pkg.sv */
package qtyd_pkg;

	// sine and cosine terms in units of 2^-30
	localparam int SC_W = 34;
	// cordic vector width, covers the cordic gain on the largest vector
	localparam int CW = 37;
	// angle accumulator in units of 2^-24 degree
	localparam int ANG_W = 34;
	localparam int YAW_W = 17;
	localparam int TAB_DEPTH = 32;

	localparam logic signed [ANG_W-1:0] ANG_180 = 34'sd3019898880;
	localparam logic signed [ANG_W-1:0] ANG_HALF_LSB = 34'sd32768;
	localparam logic signed [ANG_W-17:0] YAW_LIMIT = 18'sd46080;

	typedef struct packed {
		logic valid;
		logic zero;
	} qtyd_ctl_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} qtyd_pass_t;

	// atan(2^-i) in degrees, units of 2^-24
	function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0: r = 34'sd754974720;
			1: r = 34'sd445687602;
			2: r = 34'sd235489088;
			3: r = 34'sd119537938;
			4: r = 34'sd60000934;
			5: r = 34'sd30029717;
			6: r = 34'sd15018523;
			7: r = 34'sd7509720;
			8: r = 34'sd3754917;
			9: r = 34'sd1877466;
			10: r = 34'sd938734;
			11: r = 34'sd469367;
			12: r = 34'sd234684;
			13: r = 34'sd117342;
			14: r = 34'sd58671;
			15: r = 34'sd29335;
			16: r = 34'sd14668;
			17: r = 34'sd7334;
			18: r = 34'sd3667;
			19: r = 34'sd1833;
			20: r = 34'sd917;
			21: r = 34'sd458;
			22: r = 34'sd229;
			23: r = 34'sd115;
			24: r = 34'sd57;
			25: r = 34'sd29;
			26: r = 34'sd14;
			27: r = 34'sd7;
			28: r = 34'sd4;
			29: r = 34'sd2;
			30: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* src/qtyd_cordic_stage.sv */
module qtyd_cordic_stage import qtyd_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  qtyd_ctl_t               ctl_in,
	input  qtyd_pass_t              pass_in,
	input  logic signed [CW-1:0]    vx_in,
	input  logic signed [CW-1:0]    vy_in,
	input  logic signed [ANG_W-1:0] ang_in,
	output qtyd_ctl_t               ctl_out,
	output qtyd_pass_t              pass_out,
	output logic signed [CW-1:0]    vx_out,
	output logic signed [CW-1:0]    vy_out,
	output logic signed [ANG_W-1:0] ang_out
);

	localparam logic signed [ANG_W-1:0] STEP_ANG = atan_deg(SHIFT);

	logic signed [CW-1:0]    dx;
	logic signed [CW-1:0]    dy;
	logic signed [CW-1:0]    vx_nxt;
	logic signed [CW-1:0]    vy_nxt;
	logic signed [ANG_W-1:0] ang_nxt;

	always_comb begin
		dx = vy_in >>> SHIFT;
		dy = vx_in >>> SHIFT;
		// rotate toward the x axis
		if (!vy_in[CW-1]) begin
			vx_nxt  = vx_in + dx;
			vy_nxt  = vy_in - dy;
			ang_nxt = ang_in + STEP_ANG;
		end else begin
			vx_nxt  = vx_in - dx;
			vy_nxt  = vy_in + dy;
			ang_nxt = ang_in - STEP_ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_out <= pass_in;
			vx_out   <= vx_nxt;
			vy_out   <= vy_nxt;
			ang_out  <= ang_nxt;
		end
	end

endmodule

/* src/quaternion_to_yaw_degrees_core.sv */
// Quaternion to yaw heading. Each item carries a planar position (Q16.16) and an
// orientation quaternion (Q1.15); the result carries the position unchanged and
// the heading atan2(2(wz+xy), 1-2(y^2+z^2)) in degrees, Q9.8, -180..+180.
// Fully pipelined: one item per cycle, passing through the stages in order
// (products, term sums, half-plane fold, one stage per cordic iteration capped at
// 32, then round and saturate into the output register). All stages advance
// together; they hold only while a result sits in the output register unaccepted.
// Both terms zero gives a heading of zero.
module quaternion_to_yaw_degrees_core import qtyd_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [31:0]      pos_x,
	input  logic signed [31:0]      pos_y,
	input  logic signed [15:0]      quat_x,
	input  logic signed [15:0]      quat_y,
	input  logic signed [15:0]      quat_z,
	input  logic signed [15:0]      quat_w,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [YAW_W-1:0] yaw_deg
);

	localparam int NIT = (CORDIC_ITERATIONS > TAB_DEPTH) ? TAB_DEPTH : CORDIC_ITERATIONS;

	logic en;

	// stage 1: products
	logic               valid_s1;
	qtyd_pass_t         pass_s1;
	logic signed [31:0] p_wz_s1;
	logic signed [31:0] p_xy_s1;
	logic signed [31:0] p_yy_s1;
	logic signed [31:0] p_zz_s1;

	// stage 2: sine and cosine terms
	logic                   valid_s2;
	qtyd_pass_t             pass_s2;
	logic signed [SC_W-1:0] sin_s2;
	logic signed [SC_W-1:0] cos_s2;
	logic signed [SC_W-1:0] sin_sum;
	logic signed [SC_W-1:0] sq_sum;

	// stage 3: fold into the right half plane
	qtyd_ctl_t               ctl_s3;
	qtyd_pass_t              pass_s3;
	logic signed [CW-1:0]    vx_s3;
	logic signed [CW-1:0]    vy_s3;
	logic signed [ANG_W-1:0] ang_s3;

	qtyd_ctl_t               ctl_c  [NIT+1];
	qtyd_pass_t              pass_c [NIT+1];
	logic signed [CW-1:0]    vx_c   [NIT+1];
	logic signed [CW-1:0]    vy_c   [NIT+1];
	logic signed [ANG_W-1:0] ang_c  [NIT+1];

	logic signed [ANG_W-1:0] ang_rnd;
	logic signed [ANG_W-17:0] yaw_full;
	logic signed [YAW_W-1:0] yaw_sat;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctl_s3   <= '0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			ctl_s3.valid <= valid_s2;
			ctl_s3.zero  <= (sin_s2 == '0) && (cos_s2 == '0);
		end
	end

	assign sin_sum = SC_W'(p_wz_s1) + SC_W'(p_xy_s1);
	assign sq_sum  = SC_W'(p_yy_s1) + SC_W'(p_zz_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s1.pos_x <= pos_x;
			pass_s1.pos_y <= pos_y;
			p_wz_s1 <= 32'(quat_w) * 32'(quat_z);
			p_xy_s1 <= 32'(quat_x) * 32'(quat_y);
			p_yy_s1 <= 32'(quat_y) * 32'(quat_y);
			p_zz_s1 <= 32'(quat_z) * 32'(quat_z);

			pass_s2 <= pass_s1;
			sin_s2  <= sin_sum <<< 1;
			cos_s2  <= (SC_W'(1) <<< 30) - (sq_sum <<< 1);

			pass_s3 <= pass_s2;
			if (cos_s2[SC_W-1]) begin
				vx_s3  <= -CW'(cos_s2);
				vy_s3  <= -CW'(sin_s2);
				ang_s3 <= sin_s2[SC_W-1] ? -ANG_180 : ANG_180;
			end else begin
				vx_s3  <= CW'(cos_s2);
				vy_s3  <= CW'(sin_s2);
				ang_s3 <= '0;
			end
		end
	end

	assign ctl_c[0]  = ctl_s3;
	assign pass_c[0] = pass_s3;
	assign vx_c[0]   = vx_s3;
	assign vy_c[0]   = vy_s3;
	assign ang_c[0]  = ang_s3;

	for (genvar i = 0; i < NIT; i++) begin : g_iter
		qtyd_cordic_stage #(
			.SHIFT(i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_in   (ctl_c[i]),
			.pass_in  (pass_c[i]),
			.vx_in    (vx_c[i]),
			.vy_in    (vy_c[i]),
			.ang_in   (ang_c[i]),
			.ctl_out  (ctl_c[i+1]),
			.pass_out (pass_c[i+1]),
			.vx_out   (vx_c[i+1]),
			.vy_out   (vy_c[i+1]),
			.ang_out  (ang_c[i+1])
		);
	end

	// round half up to Q9.8, then clamp to +-180 degrees; zero terms give zero
	always_comb begin
		ang_rnd  = ang_c[NIT] + ANG_HALF_LSB;
		yaw_full = ang_rnd[ANG_W-1:16];
		if (ctl_c[NIT].zero) begin
			yaw_sat = '0;
		end else if (yaw_full > YAW_LIMIT) begin
			yaw_sat = YAW_W'(YAW_LIMIT);
		end else if (yaw_full < -YAW_LIMIT) begin
			yaw_sat = -YAW_W'(YAW_LIMIT);
		end else begin
			yaw_sat = YAW_W'(yaw_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_c[NIT].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x   <= pass_c[NIT].pos_x;
			out_y   <= pass_c[NIT].pos_y;
			yaw_deg <= yaw_sat;
		end
	end

endmodule

/* src/qtyd_checker.sv */
`include "quaternion_to_yaw_degrees_core_assert.svh"

module qtyd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [16:0] yaw_deg
);

	// a result left waiting keeps its payload
	`QTYD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(yaw_deg), "stalled result changed")

	// heading never leaves the half-turn range
	`QTYD_ASSERT_NOW(a_yaw_range, clk, arst_n, out_valid, (yaw_deg <= 17'sd46080) && (yaw_deg >= -17'sd46080), "yaw out of range")

	// an empty output register never blocks the input
	`QTYD_ASSERT_NOW(a_ready_empty, clk, arst_n, !out_valid, in_ready, "input blocked with empty output")

	// a taken result frees the pipe for a new item
	`QTYD_ASSERT_NOW(a_ready_taken, clk, arst_n, out_valid && out_ready, in_ready, "input blocked while result taken")

endmodule

bind quaternion_to_yaw_degrees_core qtyd_checker u_qtyd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_x     (out_x),
	.out_y     (out_y),
	.yaw_deg   (yaw_deg)
);
